### hw/rtl/rsmp_pkg.sv
// Shared types, constants and register codes of the 12-bit rejection sampler.
package rsmp_pkg;

	localparam int BYTE_W   = 8;
	localparam int CAND_W   = 12;
	localparam int MOD_W    = 13;
	localparam int CNT_W    = 9;
	localparam int IDX_W    = 8;
	localparam int CFG_W    = 13;
	localparam int CFG_AW   = 1;

	// Upper bound on the coefficient count; larger settings saturate here.
	localparam int MAX_COEFFS = 256;

	// Default depth of the queue between front and back, in result pairs.
	localparam int QDEPTH_DEF = 4;

	localparam logic [MOD_W-1:0] MOD_RESET = 13'd3329;
	localparam logic [CNT_W-1:0] CNT_RESET = 9'd256;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] REG_MODULUS     = 1'b0;
	localparam logic [CFG_AW-1:0] REG_COEFF_COUNT = 1'b1;

	typedef struct packed {
		logic [CAND_W-1:0] coeff;
		logic [IDX_W-1:0]  coeff_index;
		logic              last;
	} rsmp_res_t;

	// Results of one byte triple: one or two coefficients, first in res0.
	typedef struct packed {
		logic      two;
		rsmp_res_t res0;
		rsmp_res_t res1;
	} rsmp_pair_t;

endpackage

### hw/rtl/rsmp_front.sv
// Front end: byte grouping, candidate check and coefficient counting.
module rsmp_front import rsmp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_AW-1:0]    cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    in_byte,
	input  logic                 in_start,
	input  logic                 in_bend,
	input  logic                 q_full,
	output logic                 push,
	output rsmp_pair_t           push_pair
);

	logic [MOD_W-1:0]  modulus_q;
	logic [CNT_W-1:0]  coeff_count_q;
	logic [1:0]        phase_q;
	logic [BYTE_W-1:0] held0_q;
	logic [BYTE_W-1:0] held1_q;
	logic [CNT_W-1:0]  acc_cnt_q;

	logic              take;
	logic [CNT_W-1:0]  eff_n;
	logic [CNT_W-1:0]  cnt0;
	logic [CNT_W-1:0]  cnt1;
	logic [CNT_W-1:0]  cnt2;
	logic [1:0]        ph0;
	logic              active;
	logic [CAND_W-1:0] c0;
	logic [CAND_W-1:0] c1;
	logic              acc0;
	logic              acc1;
	rsmp_res_t         r0;
	rsmp_res_t         r1;
	logic [1:0]        ph_next;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	always_comb begin
		eff_n  = (coeff_count_q > CNT_W'(MAX_COEFFS)) ? CNT_W'(MAX_COEFFS) : coeff_count_q;
		cnt0   = in_start ? '0 : acc_cnt_q;
		ph0    = (in_start || phase_q == 2'd3) ? 2'd0 : phase_q;
		active = cnt0 < eff_n;
		c0     = {held1_q[3:0], held0_q};
		c1     = {in_byte, held1_q[7:4]};
		acc0   = active && (ph0 == 2'd2) && ({1'b0, c0} < modulus_q);
		cnt1   = cnt0 + CNT_W'(acc0);
		acc1   = (ph0 == 2'd2) && (cnt1 < eff_n) && ({1'b0, c1} < modulus_q);
		cnt2   = cnt1 + CNT_W'(acc1);

		r0.coeff       = c0;
		r0.coeff_index = cnt0[IDX_W-1:0];
		r0.last        = (cnt0 + 1'b1) == eff_n;
		r1.coeff       = c1;
		r1.coeff_index = cnt1[IDX_W-1:0];
		r1.last        = (cnt1 + 1'b1) == eff_n;

		push_pair.two  = acc0 && acc1;
		push_pair.res0 = acc0 ? r0 : r1;
		push_pair.res1 = r1;
		push           = take && (acc0 || acc1);

		ph_next = ph0;
		if (active) begin
			case (ph0)
				2'd0:    ph_next = 2'd1;
				2'd1:    ph_next = 2'd2;
				default: ph_next = 2'd0;
			endcase
		end
		if (in_bend) begin
			ph_next = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q     <= MOD_RESET;
			coeff_count_q <= CNT_RESET;
			phase_q       <= 2'd0;
			acc_cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_MODULUS:     modulus_q     <= cfg_wdata[MOD_W-1:0];
					REG_COEFF_COUNT: coeff_count_q <= cfg_wdata[CNT_W-1:0];
					default: ;
				endcase
			end
			if (take) begin
				phase_q   <= ph_next;
				acc_cnt_q <= cnt2;
			end
		end
	end

	// Held bytes carry payload only; phase guards every read.
	always_ff @(posedge clk) begin
		if (take && active && ph0 == 2'd0) begin
			held0_q <= in_byte;
		end
		if (take && active && ph0 == 2'd1) begin
			held1_q <= in_byte;
		end
	end

endmodule

### hw/rtl/rsmp_fifo.sv
// Small queue of result pairs between the front end and the output stage.
module rsmp_fifo import rsmp_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rsmp_pair_t push_pair,
	input  logic       pop,
	output rsmp_pair_t head,
	output logic       empty,
	output logic       full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rsmp_pair_t      mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_pair;
		end
	end

endmodule

### hw/rtl/rsmp_back.sv
// Output stage: splits queued pairs into single coefficient words.
module rsmp_back import rsmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rsmp_pair_t        head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CAND_W-1:0] out_coeff,
	output logic [IDX_W-1:0]  out_index,
	output logic              out_last
);

	logic              valid_q;
	logic              sel_q;
	logic [CAND_W-1:0] coeff_q;
	logic [IDX_W-1:0]  index_q;
	logic              last_q;
	logic              load;
	rsmp_res_t         pick;

	assign load = !valid_q || out_ready;
	assign pick = sel_q ? head.res1 : head.res0;
	assign pop  = load && !empty && (sel_q || !head.two);

	assign out_valid = valid_q;
	assign out_coeff = coeff_q;
	assign out_index = index_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				sel_q <= !pop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			coeff_q <= pick.coeff;
			index_q <= pick.coeff_index;
			last_q  <= pick.last;
		end
	end

endmodule

### hw/rtl/rejection_sampler_12bit_top.sv
// Top level of the 12-bit rejection sampler: byte stream in, coefficients out.
//
//  channel     dir  handshake           payload
//  s_axis      in   s_tvalid/s_tready   s_tdata[7:0] stream_byte, s_tuser start_req,
//                                        s_tlast block_end
//  m_axis      out  m_tvalid/m_tready   m_tdata[11:0] coeff, [19:12] coeff_index,
//                                        [23:20] zero, m_tlast last
//  cfg         in   cfg_we              cfg_addr register index, cfg_wdata value
//
// One byte is taken per cycle while the pair queue is not full. Words of a triple
// pass through the pair queue and then the output register; at most one word
// leaves per cycle, set by the output register draining the pair queue.
// Reset clears the byte phase, the coefficient count, the queue and the output
// valid flag and loads modulus 3329 and count 256; no clearing pass is needed.
// s_tready drops only on a full pair queue; with QDEPTH > 1 that takes a stalled m side.
module rejection_sampler_12bit_top import rsmp_pkg::*; #(
	parameter int QDEPTH = QDEPTH_DEF // result pairs held between front and back, >= 1
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration writes
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata,
	// byte stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // [7:0] stream_byte
	input  logic              s_tuser,  // [0] start_req
	input  logic              s_tlast,  // block_end
	// coefficient stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,  // [11:0] coeff, [19:12] coeff_index, [23:20] zero
	output logic              m_tlast   // last
);

	logic              push;
	rsmp_pair_t        push_pair;
	logic              pop;
	rsmp_pair_t        head;
	logic              q_empty;
	logic              q_full;
	logic [CAND_W-1:0] coeff;
	logic [IDX_W-1:0]  coeff_index;

	// Front: group bytes, test candidates, count coefficients.
	rsmp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_start  (s_tuser),
		.in_bend   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_pair (push_pair)
	);

	// Queue: decouple the byte side from output stalls.
	rsmp_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_pair (push_pair),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Back: issue each queued coefficient as its own word.
	rsmp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_coeff (coeff),
		.out_index (coeff_index),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'd0, coeff_index, coeff};

endmodule

### hw/rtl/rsmp_checker.sv
// Port-level checks of the rejection sampler, bound to the top level.
module rsmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	logic seen_q;

	// Remember that at least one byte went in since reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			seen_q <= 1'b1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_tvalid)
		else $error("output word right after reset");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> seen_q)
		else $error("output word without any input byte");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:20] == 4'd0)
		else $error("padding bits of output word not zero");

endmodule

bind rejection_sampler_12bit_top rsmp_checker u_rsmp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
